FILE: rtl/core/nv12ro_pkg.sv
// Shared types and constants for the NV12 rectangle overlay.
// Used by nv12ro_cfg, nv12ro_back and the top level; depends on nothing else.
package nv12ro_pkg;

  localparam int ADDR_W      = 5;
  localparam int DIM_W       = 13;
  localparam int POS_W       = 12;
  localparam int COLOR_W     = 24;
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH  = 3'd0,
    REG_IMAGE_HEIGHT = 3'd1,
    REG_RECT_LEFT    = 3'd2,
    REG_RECT_TOP     = 3'd3,
    REG_RECT_WIDTH   = 3'd4,
    REG_RECT_HEIGHT  = 3'd5,
    REG_BOX_COLOR    = 3'd6
  } reg_idx_t;

  localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [POS_W-1:0]   RST_RECT_LEFT    = 12'd0;
  localparam logic [POS_W-1:0]   RST_RECT_TOP     = 12'd0;
  localparam logic [POS_W-1:0]   RST_RECT_WIDTH   = 12'd8;
  localparam logic [POS_W-1:0]   RST_RECT_HEIGHT  = 12'd8;
  localparam logic [COLOR_W-1:0] RST_BOX_COLOR    = 24'd1927151;

  // Both sides of the rectangle must exceed this to be drawn.
  localparam logic [POS_W-1:0] MIN_RECT_SIZE = 12'd4;

  typedef struct packed {
    logic [DIM_W-1:0]   image_width;
    logic [DIM_W-1:0]   image_height;
    logic [POS_W-1:0]   rect_left;
    logic [POS_W-1:0]   rect_top;
    logic [POS_W-1:0]   rect_width;
    logic [POS_W-1:0]   rect_height;
    logic [COLOR_W-1:0] box_color;
  } cfg_regs_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       on_border;
    logic       rect_valid;
    logic       last_of_frame;
  } result_t;

endpackage

FILE: rtl/core/nv12ro_cfg.sv
// Configuration register file with an APB-style port, plus the derived
// effective frame size and rectangle validity. Depends on nv12ro_pkg.
module nv12ro_cfg #(
  parameter int MAX_DIM_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nv12ro_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output nv12ro_pkg::cfg_regs_t          cfg,
  output logic [MAX_DIM_BITS:0]          eff_width,
  output logic [MAX_DIM_BITS:0]          eff_height,
  output logic                           rect_valid
);
  import nv12ro_pkg::*;

  localparam int DW = MAX_DIM_BITS + 1;
  localparam int XW = (DW > DIM_W) ? DW : DIM_W;
  localparam logic [XW-1:0] MAX_DIM = XW'(1) << MAX_DIM_BITS;

  cfg_regs_t        cfg_r, cfg_nxt;
  logic             wr_en;
  reg_idx_t         idx;
  logic [DIM_W-1:0] right_edge, bottom_edge;

  // Odd sizes round down, and the size is clamped between 2 and what the counters hold.
  function automatic logic [DW-1:0] eff_dim(input logic [DIM_W-1:0] v);
    logic [XW-1:0] e;
    e = XW'(v) & ~XW'(1);
    if (e < XW'(2)) e = XW'(2);
    if (e > MAX_DIM) e = MAX_DIM;
    return e[DW-1:0];
  endfunction

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_IMAGE_WIDTH:  cfg_nxt.image_width  = pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_nxt.image_height = pwdata[DIM_W-1:0];
        REG_RECT_LEFT:    cfg_nxt.rect_left    = pwdata[POS_W-1:0];
        REG_RECT_TOP:     cfg_nxt.rect_top     = pwdata[POS_W-1:0];
        REG_RECT_WIDTH:   cfg_nxt.rect_width   = pwdata[POS_W-1:0];
        REG_RECT_HEIGHT:  cfg_nxt.rect_height  = pwdata[POS_W-1:0];
        REG_BOX_COLOR:    cfg_nxt.box_color    = pwdata[COLOR_W-1:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= RST_IMAGE_WIDTH;
      cfg_r.image_height <= RST_IMAGE_HEIGHT;
      cfg_r.rect_left    <= RST_RECT_LEFT;
      cfg_r.rect_top     <= RST_RECT_TOP;
      cfg_r.rect_width   <= RST_RECT_WIDTH;
      cfg_r.rect_height  <= RST_RECT_HEIGHT;
      cfg_r.box_color    <= RST_BOX_COLOR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  always_comb begin
    case (idx)
      REG_IMAGE_WIDTH:  prdata = 32'(cfg_r.image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(cfg_r.image_height);
      REG_RECT_LEFT:    prdata = 32'(cfg_r.rect_left);
      REG_RECT_TOP:     prdata = 32'(cfg_r.rect_top);
      REG_RECT_WIDTH:   prdata = 32'(cfg_r.rect_width);
      REG_RECT_HEIGHT:  prdata = 32'(cfg_r.rect_height);
      REG_BOX_COLOR:    prdata = 32'(cfg_r.box_color);
      default:          prdata = 32'd0;
    endcase
  end

  assign cfg        = cfg_r;
  assign eff_width  = eff_dim(cfg_r.image_width);
  assign eff_height = eff_dim(cfg_r.image_height);

  assign right_edge  = {1'b0, cfg_r.rect_left} + {1'b0, cfg_r.rect_width};
  assign bottom_edge = {1'b0, cfg_r.rect_top} + {1'b0, cfg_r.rect_height};

  assign rect_valid = (cfg_r.rect_width > MIN_RECT_SIZE) &&
                      (cfg_r.rect_height > MIN_RECT_SIZE) &&
                      (XW'(right_edge) < XW'(eff_width)) &&
                      (XW'(bottom_edge) < XW'(eff_height));

endmodule

FILE: rtl/core/nv12ro_fifo.sv
// Small register-based first-in first-out queue.
// Generic; depends on nothing. DEPTH must be a power of two.
module nv12ro_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt, rptr_r, rptr_nxt;
  logic [AW:0]      count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (AW+1)'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt  = do_push ? wptr_r + AW'(1) : wptr_r;
    rptr_nxt  = do_pop ? rptr_r + AW'(1) : rptr_r;
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

endmodule

FILE: rtl/core/nv12ro_front.sv
// Front end: accepts frame bytes, tracks plane, row and column, and tags
// each byte with its position and the end-of-frame mark. Depends on nothing.
module nv12ro_front #(
  parameter int MAX_DIM_BITS = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              push,
  input  logic [7:0]                        pixel_byte,
  input  logic                              start_of_frame,
  input  logic                              q_full,
  input  logic [MAX_DIM_BITS:0]             eff_width,
  input  logic [MAX_DIM_BITS:0]             eff_height,
  output logic                              q_push,
  output logic [2*MAX_DIM_BITS+9:0]         q_item
);
  localparam int CW = MAX_DIM_BITS;
  localparam int DW = MAX_DIM_BITS + 1;

  logic [CW-1:0] col_r, col_nxt, row_r, row_nxt;
  logic          chroma_r, chroma_nxt;
  logic [CW-1:0] col_cur, row_cur;
  logic          chroma_cur;
  logic [DW-1:0] rows_here;
  logic          col_end, row_end, last;

  assign q_push = push & ~q_full;

  // A start mark moves the position to the frame origin before this byte.
  assign col_cur    = start_of_frame ? '0 : col_r;
  assign row_cur    = start_of_frame ? '0 : row_r;
  assign chroma_cur = start_of_frame ? 1'b0 : chroma_r;

  assign rows_here = chroma_cur ? (eff_height >> 1) : eff_height;
  assign col_end   = (DW'(col_cur) + DW'(1)) >= eff_width;
  assign row_end   = (DW'(row_cur) + DW'(1)) >= rows_here;
  assign last      = chroma_cur & row_end & col_end;

  assign q_item = {pixel_byte, row_cur, col_cur, chroma_cur, last};

  always_comb begin
    col_nxt    = col_r;
    row_nxt    = row_r;
    chroma_nxt = chroma_r;
    if (q_push) begin
      row_nxt    = row_cur;
      chroma_nxt = chroma_cur;
      if (col_end) begin
        col_nxt = '0;
        if (row_end) begin
          row_nxt    = '0;
          chroma_nxt = ~chroma_cur;
        end else begin
          row_nxt = row_cur + CW'(1);
        end
      end else begin
        col_nxt = col_cur + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r    <= '0;
      row_r    <= '0;
      chroma_r <= 1'b0;
    end else begin
      col_r    <= col_nxt;
      row_r    <= row_nxt;
      chroma_r <= chroma_nxt;
    end
  end

endmodule

FILE: rtl/core/nv12ro_back.sv
// Back end: takes tagged bytes from the queue, decides whether each lies on
// the rectangle border and substitutes the colour. Depends on nv12ro_pkg.
module nv12ro_back #(
  parameter int MAX_DIM_BITS = 12,
  parameter int BORDER_W     = 2
) (
  input  nv12ro_pkg::cfg_regs_t       cfg,
  input  logic                        rect_valid,
  input  logic                        q_empty,
  input  logic [2*MAX_DIM_BITS+9:0]   q_item,
  output logic                        q_pop,
  input  logic                        res_full,
  output logic                        res_push,
  output nv12ro_pkg::result_t         res
);
  import nv12ro_pkg::*;

  localparam int CW = MAX_DIM_BITS;
  localparam int GW = (CW + 2 > 14) ? CW + 2 : 14;
  localparam logic [GW-1:0] LW = GW'(BORDER_W);

  logic [7:0]    pix;
  logic [CW-1:0] row, col;
  logic          chroma, last;
  logic [GW-1:0] x, y, w, h, lr, lc;
  logic          hit_raw, hit;
  logic [7:0]    colour;

  // A luma pixel is on the border when it lies in the box and within
  // BORDER_W of one of its edges.
  function automatic logic luma_on(input logic [GW-1:0] r, input logic [GW-1:0] c,
                                   input logic [GW-1:0] bx, input logic [GW-1:0] by,
                                   input logic [GW-1:0] bw, input logic [GW-1:0] bh);
    logic in_box, row_edge, col_edge;
    in_box   = !(r < by || r > by + bh || c < bx || c + GW'(1) > bx + bw);
    row_edge = (r < by + LW) || (r + LW > by + bh);
    col_edge = (c < bx + LW) || (c + LW >= bx + bw);
    return in_box && (row_edge || col_edge);
  endfunction

  assign {pix, row, col, chroma, last} = q_item;

  assign x = GW'(cfg.rect_left);
  assign y = GW'(cfg.rect_top);
  assign w = GW'(cfg.rect_width);
  assign h = GW'(cfg.rect_height);

  // A chroma pair covers the 2x2 luma block below and right of (lr, lc).
  assign lr = GW'(row) << 1;
  assign lc = GW'(col) & ~GW'(1);

  always_comb begin
    if (chroma) begin
      hit_raw = luma_on(lr, lc, x, y, w, h) ||
                luma_on(lr, lc + GW'(1), x, y, w, h) ||
                luma_on(lr + GW'(1), lc, x, y, w, h) ||
                luma_on(lr + GW'(1), lc + GW'(1), x, y, w, h);
      colour  = col[0] ? cfg.box_color[7:0] : cfg.box_color[15:8];
    end else begin
      hit_raw = luma_on(GW'(row), GW'(col), x, y, w, h);
      colour  = cfg.box_color[23:16];
    end
  end

  assign hit = rect_valid & hit_raw;

  assign q_pop    = ~q_empty & ~res_full;
  assign res_push = q_pop;

  assign res.out_byte      = hit ? colour : pix;
  assign res.on_border     = hit;
  assign res.rect_valid    = rect_valid;
  assign res.last_of_frame = last;

endmodule

FILE: rtl/core/nv12_rectangle_overlay.sv
// NV12 rectangle overlay: takes one frame byte per clock (luma plane, then
// interleaved U/V) and paints a BORDER_W-thick rectangle border in the
// configured colour. It sustains one byte per clock on both sides while no
// queue is full and the output is popped; a byte passes the four-entry queue
// between the position tracker and the combinational border compare, then
// the four-entry result queue. The user must write registers over the APB
// port only while no byte is in flight; the block itself does not enforce it.
// Depends on nv12ro_pkg, nv12ro_cfg, nv12ro_fifo, nv12ro_front, nv12ro_back.
module nv12_rectangle_overlay #(
  parameter int MAX_DIM_BITS = 12,
  parameter int BORDER_W     = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_pixel_byte,
  input  logic                          in_start_of_frame,
  input  logic                          pop,
  output logic                          empty,
  output logic [7:0]                    out_byte,
  output logic                          out_on_border,
  output logic                          out_rect_valid,
  output logic                          out_last_of_frame,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [nv12ro_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import nv12ro_pkg::*;

  localparam int ITEM_W = 2 * MAX_DIM_BITS + 10;
  localparam int RES_W  = $bits(result_t);

  cfg_regs_t             cfg;
  logic [MAX_DIM_BITS:0] eff_width, eff_height;
  logic                  rect_valid;
  logic                  q_push, q_full, q_pop, q_empty;
  logic [ITEM_W-1:0]     q_wdata, q_rdata;
  logic                  res_push, res_full;
  result_t               res, res_head;
  logic [RES_W-1:0]      res_rdata;

  nv12ro_cfg #(.MAX_DIM_BITS(MAX_DIM_BITS)) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .cfg        (cfg),
    .eff_width  (eff_width),
    .eff_height (eff_height),
    .rect_valid (rect_valid)
  );

  nv12ro_front #(.MAX_DIM_BITS(MAX_DIM_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .pixel_byte     (in_pixel_byte),
    .start_of_frame (in_start_of_frame),
    .q_full         (q_full),
    .eff_width      (eff_width),
    .eff_height     (eff_height),
    .q_push         (q_push),
    .q_item         (q_wdata)
  );

  nv12ro_fifo #(.WIDTH(ITEM_W), .DEPTH(QUEUE_DEPTH)) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  nv12ro_back #(.MAX_DIM_BITS(MAX_DIM_BITS), .BORDER_W(BORDER_W)) u_back (
    .cfg        (cfg),
    .rect_valid (rect_valid),
    .q_empty    (q_empty),
    .q_item     (q_rdata),
    .q_pop      (q_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res)
  );

  nv12ro_fifo #(.WIDTH(RES_W), .DEPTH(QUEUE_DEPTH)) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign full              = q_full;
  assign res_head          = result_t'(res_rdata);
  assign out_byte          = res_head.out_byte;
  assign out_on_border     = res_head.on_border;
  assign out_rect_valid    = res_head.rect_valid;
  assign out_last_of_frame = res_head.last_of_frame;

endmodule

FILE: rtl/core/nv12ro_checker.sv
// Port-level checks for the NV12 rectangle overlay, bound to the top level.
// Depends on nv12_rectangle_overlay.
module nv12ro_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       pop,
  input logic       empty,
  input logic [7:0] out_byte,
  input logic       out_on_border,
  input logic       out_rect_valid,
  input logic       out_last_of_frame
);

  // Both queues come out of reset empty.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  // A byte is only replaced when the rectangle is drawable.
  a_border_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_on_border |-> out_rect_valid)
    else $error("border byte reported with an invalid rectangle");

  // A waiting result stays put until its transfer.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(out_on_border) &&
                       $stable(out_last_of_frame))
    else $error("waiting result changed before transfer");

endmodule

bind nv12_rectangle_overlay nv12ro_checker u_nv12ro_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .full              (full),
  .pop               (pop),
  .empty             (empty),
  .out_byte          (out_byte),
  .out_on_border     (out_on_border),
  .out_rect_valid    (out_rect_valid),
  .out_last_of_frame (out_last_of_frame)
);

FILE: dv/nv12_rectangle_overlay_tb.sv
// Self-checking testbench for nv12_rectangle_overlay: byte stream in, painted byte stream out.
// A scoreboard class predicts every result; tasks drive the byte queue and the APB port.
// Depends on nv12ro_pkg and the nv12_rectangle_overlay RTL.
`timescale 1ns / 100ps

module nv12_rectangle_overlay_tb;
  import nv12ro_pkg::*;

  localparam int MAX_DIM = 12;
  localparam int LINE_W = 2;
  localparam int unsigned POS_MASK = (1 << MAX_DIM) - 1;
  localparam int unsigned TARGET_BYTES = 1450;
  localparam int CYCLE_LIMIT = 200000;

  class overlay_scoreboard;
    cfg_regs_t regs;
    int unsigned col_pos, row_pos;
    bit chroma_plane;
    result_t expected_bytes[$];
    int unsigned mismatches, checked;

    function new();
      regs.image_width = RST_IMAGE_WIDTH;
      regs.image_height = RST_IMAGE_HEIGHT;
      regs.rect_left = RST_RECT_LEFT;
      regs.rect_top = RST_RECT_TOP;
      regs.rect_width = RST_RECT_WIDTH;
      regs.rect_height = RST_RECT_HEIGHT;
      regs.box_color = RST_BOX_COLOR;
      col_pos = 0;
      row_pos = 0;
      chroma_plane = 1'b0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void write_reg(reg_idx_t idx, bit [31:0] v);
      case (idx)
        REG_IMAGE_WIDTH: regs.image_width = v[DIM_W-1:0];
        REG_IMAGE_HEIGHT: regs.image_height = v[DIM_W-1:0];
        REG_RECT_LEFT: regs.rect_left = v[POS_W-1:0];
        REG_RECT_TOP: regs.rect_top = v[POS_W-1:0];
        REG_RECT_WIDTH: regs.rect_width = v[POS_W-1:0];
        REG_RECT_HEIGHT: regs.rect_height = v[POS_W-1:0];
        REG_BOX_COLOR: regs.box_color = v[COLOR_W-1:0];
        default: ;
      endcase
    endfunction

    // Frame size as the block uses it: even, between 2 and 2^MAX_DIM.
    function int unsigned eff_dim(int unsigned v);
      int unsigned d;
      d = v & 32'hFFFF_FFFE;
      if (d < 2) d = 2;
      if (d > (1 << MAX_DIM)) d = 1 << MAX_DIM;
      return d;
    endfunction

    function bit on_luma_border(int unsigned r, int unsigned c);
      int unsigned x, y, w, h;
      x = regs.rect_left;
      y = regs.rect_top;
      w = regs.rect_width;
      h = regs.rect_height;
      if (r < y || r > y + h || c < x || c + 1 > x + w) return 1'b0;
      if (r < y + LINE_W || r + LINE_W > y + h) return 1'b1;
      if (c < x + LINE_W || c + LINE_W >= x + w) return 1'b1;
      return 1'b0;
    endfunction

    function void predict_byte(bit [7:0] pix, bit sof);
      int unsigned wf, hf, rows, lr, lc;
      bit valid, hit, last;
      bit [7:0] paint;
      result_t exp_r;
      wf = eff_dim(regs.image_width);
      hf = eff_dim(regs.image_height);
      hit = 1'b0;
      paint = 8'h00;
      if (sof) begin
        col_pos = 0;
        row_pos = 0;
        chroma_plane = 1'b0;
      end
      valid = regs.rect_width > 4 && regs.rect_height > 4 &&
              int'(regs.rect_left) + int'(regs.rect_width) < wf &&
              int'(regs.rect_top) + int'(regs.rect_height) < hf;
      if (valid) begin
        if (!chroma_plane) begin
          hit = on_luma_border(row_pos, col_pos);
          paint = regs.box_color[23:16];
        end else begin
          // A chroma pair covers a 2x2 block of luma pixels.
          lr = row_pos << 1;
          lc = col_pos & 32'hFFFF_FFFE;
          hit = on_luma_border(lr, lc) || on_luma_border(lr, lc + 1) ||
                on_luma_border(lr + 1, lc) || on_luma_border(lr + 1, lc + 1);
          paint = col_pos[0] ? regs.box_color[7:0] : regs.box_color[15:8];
        end
      end
      rows = chroma_plane ? (hf >> 1) : hf;
      last = chroma_plane && row_pos + 1 >= rows && col_pos + 1 >= wf;
      exp_r.out_byte = hit ? paint : pix;
      exp_r.on_border = hit;
      exp_r.rect_valid = valid;
      exp_r.last_of_frame = last;
      expected_bytes.push_back(exp_r);
      if (col_pos + 1 >= wf) begin
        col_pos = 0;
        if (row_pos + 1 >= rows) begin
          row_pos = 0;
          chroma_plane = ~chroma_plane;
        end else begin
          row_pos = (row_pos + 1) & POS_MASK;
        end
      end else begin
        col_pos = (col_pos + 1) & POS_MASK;
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_byte(result_t got);
      result_t want;
      checked++;
      if (expected_bytes.size() == 0) begin
        $display("%0t: unexpected transfer, out_byte %0h", $time, got.out_byte);
        mismatches++;
        return;
      end
      want = expected_bytes.pop_front();
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("on_border", want.on_border, got.on_border);
      compare_field("rect_valid", want.rect_valid, got.rect_valid);
      compare_field("last_of_frame", want.last_of_frame, got.last_of_frame);
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction
  endclass

  bit clk = 1'b0;
  logic rst_n;
  logic push, full, pop, empty;
  logic [7:0] in_pixel_byte;
  logic in_start_of_frame;
  logic [7:0] out_byte;
  logic out_on_border, out_rect_valid, out_last_of_frame;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;

  overlay_scoreboard sb = new();
  int unsigned sent_count = 0;
  int cycles = 0;

  nv12_rectangle_overlay dut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_pixel_byte(in_pixel_byte),
    .in_start_of_frame(in_start_of_frame),
    .pop(pop),
    .empty(empty),
    .out_byte(out_byte),
    .out_on_border(out_on_border),
    .out_rect_valid(out_rect_valid),
    .out_last_of_frame(out_last_of_frame),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL nv12_rectangle_overlay");
      $finish;
    end
  end

  // Result side: random stalls, a quiet stretch, and two long hold-offs that fill the block.
  initial begin
    result_t got;
    int hold_left, holds_done;
    hold_left = 0;
    holds_done = 0;
    pop <= 1'b0;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && !empty) begin
        got.out_byte = out_byte;
        got.on_border = out_on_border;
        got.rect_valid = out_rect_valid;
        got.last_of_frame = out_last_of_frame;
        sb.check_byte(got);
      end
      if ((holds_done == 0 && sb.checked >= 400) || (holds_done == 1 && sb.checked >= 1100)) begin
        hold_left = 150;
        holds_done++;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (sb.checked >= 700 && sb.checked < 1000) begin
        pop <= 1'b1;
      end else begin
        pop <= ($urandom_range(99) >= 11);
      end
    end
  end

  task automatic send_byte(bit [7:0] pix, bit sof);
    push <= 1'b1;
    in_pixel_byte <= pix;
    in_start_of_frame <= sof;
    do @(posedge clk); while (full);
    sb.predict_byte(pix, sof);
    sent_count++;
    if ((sent_count < 700 || sent_count >= 1000) && $urandom_range(99) < 11) begin
      push <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_frame(int unsigned nbytes, bit mark);
    for (int unsigned i = 0; i < nbytes && sent_count < TARGET_BYTES; i++)
      send_byte($urandom_range(255), (i == 0) ? mark : ($urandom_range(49) == 0));
  endtask

  // Registers change only once every transfer in flight has come out.
  task automatic wait_idle();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic apb_write(reg_idx_t idx, bit [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Sets random bits above the register width now and then; the block must ignore them.
  function automatic bit [31:0] noisy(int unsigned v, int width);
    bit [31:0] d;
    d = v;
    if ($urandom_range(3) == 0) d |= $urandom << width;
    return d;
  endfunction

  task automatic random_phase();
    int unsigned wreg, hreg, wf, hf, x, y, w, h, nbytes;
    bit big_frame;
    big_frame = 1'b0;
    wait_idle();
    if ($urandom_range(3) != 0) begin
      if ($urandom_range(14) == 0) begin
        big_frame = 1'b1;
        wreg = $urandom_range(8191, 1000);
        hreg = $urandom_range(8191, 1000);
      end else begin
        wreg = $urandom_range(16, 2);
        hreg = $urandom_range(10, 2);
        if ($urandom_range(6) == 0) wreg |= 1;
        if ($urandom_range(6) == 0) hreg |= 1;
      end
      apb_write(REG_IMAGE_WIDTH, noisy(wreg, DIM_W));
      apb_write(REG_IMAGE_HEIGHT, noisy(hreg, DIM_W));
    end
    wf = sb.eff_dim(sb.regs.image_width);
    hf = sb.eff_dim(sb.regs.image_height);
    if ($urandom_range(3) != 0 && wf >= 6 && hf >= 6) begin
      w = $urandom_range(wf - 1, 5);
      x = $urandom_range(wf - 1 - w, 0);
      h = $urandom_range(hf - 1, 5);
      y = $urandom_range(hf - 1 - h, 0);
    end else begin
      // Mostly undrawable rectangles, including the size and edge boundaries.
      w = $urandom_range(15);
      x = $urandom_range(15);
      h = $urandom_range(15);
      y = $urandom_range(15);
    end
    apb_write(REG_RECT_LEFT, noisy(x, POS_W));
    apb_write(REG_RECT_TOP, noisy(y, POS_W));
    apb_write(REG_RECT_WIDTH, noisy(w, POS_W));
    apb_write(REG_RECT_HEIGHT, noisy(h, POS_W));
    if ($urandom_range(1) == 0) apb_write(REG_BOX_COLOR, noisy($urandom_range(24'hFFFFFF), COLOR_W));
    if (big_frame || wf > 64 || hf > 64) begin
      send_frame(20, 1'b1);
    end else begin
      repeat ($urandom_range(2, 1)) begin
        nbytes = wf * hf + (hf >> 1) * wf;
        if ($urandom_range(9) == 0) nbytes = $urandom_range(nbytes, 1);
        send_frame(nbytes, $urandom_range(9) != 0);
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    push <= 1'b0;
    in_pixel_byte <= 8'h00;
    in_start_of_frame <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: the top-left rectangle in a 640x480 frame, starting without a mark.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);

    // Frame sizes below range clamp to 2x2; an oversized rectangle is not drawn.
    // Eight bytes run through one whole frame and into the next with no mark.
    wait_idle();
    apb_write(REG_IMAGE_WIDTH, 32'd1);
    apb_write(REG_IMAGE_HEIGHT, 32'd0);
    apb_write(REG_RECT_LEFT, 32'hFFFF_FFFF);
    apb_write(REG_RECT_TOP, 32'hFFFF_FFFF);
    apb_write(REG_RECT_WIDTH, 32'd0);
    apb_write(REG_RECT_HEIGHT, 32'd4095);
    send_frame(8, 1'b1);

    // Sizes above range clamp to 4096; the widest rectangle that still fits.
    wait_idle();
    apb_write(REG_IMAGE_WIDTH, 32'd8191);
    apb_write(REG_IMAGE_HEIGHT, 32'd8191);
    apb_write(REG_RECT_LEFT, 32'd0);
    apb_write(REG_RECT_TOP, 32'd0);
    apb_write(REG_RECT_WIDTH, 32'd4095);
    apb_write(REG_RECT_HEIGHT, 32'd4095);
    apb_write(REG_BOX_COLOR, 32'h00FF_FFFF);
    send_byte(8'h12, 1'b1);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b1);
    send_byte(8'h9A, 1'b0);
    send_byte(8'hBC, 1'b0);

    // Odd sizes lose bit 0; the smallest drawable rectangle in a 6x8 frame.
    wait_idle();
    apb_write(REG_IMAGE_WIDTH, 32'd7);
    apb_write(REG_IMAGE_HEIGHT, 32'd9);
    apb_write(REG_RECT_WIDTH, 32'd5);
    apb_write(REG_RECT_HEIGHT, 32'd5);
    apb_write(REG_BOX_COLOR, 32'd0);
    send_frame(5, 1'b1);

    while (sent_count < TARGET_BYTES) random_phase();
    push <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("PASS nv12_rectangle_overlay");
    end else begin
      $display("FAIL nv12_rectangle_overlay");
    end
    $finish;
  end

endmodule
